FILE: sv/schur_reduced_rhs_accumulator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reduced right-hand side accumulator
// Shared property forms used by the controller of the accumulator core.
// ----------------------------------------------------------------------------
`ifndef SCHUR_REDUCED_RHS_ACCUMULATOR_CORE_ASSERT_SVH
`define SCHUR_REDUCED_RHS_ACCUMULATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never hold.
`define SRRA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: sv/srra_pkg.sv
// ----------------------------------------------------------------------------
// Reduced right-hand side accumulator package
// Types, codes and constants shared by the accumulator modules.
// ----------------------------------------------------------------------------
package srra_pkg;

    localparam int CAMERAS_DEFAULT = 256;
    localparam int POINTS_DEFAULT  = 4096;
    localparam int ROWS_PER_CAMERA = 9;
    localparam int DIM             = 3;

    localparam logic [1:0] CMD_LOAD_POINT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_CAMERA = 2'd1;
    localparam logic [1:0] CMD_OBSERVE     = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_ADD,
        FOP_SUB
    } fpu_op_t;

    typedef struct packed {
        logic       latch;
        logic       ca_rd;
        logic       pp_rd;
        logic       pp_wr;
        logic       ca_wr_vec;
        logic       ca_wr_acc;
        logic       acc_zero;
        logic       acc_from_ca;
        logic       acc_from_fpu;
        logic       tmp_from_fpu;
        logic       fpu_start;
        fpu_op_t    fpu_op;
        logic [1:0] row;
        logic [1:0] col;
        logic       result_strobe;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       addr_ok;
        logic       pt_ok;
        logic       fpu_done;
    } stat_t;

    function automatic logic [2:0] tri_index(input logic [1:0] row, input logic [1:0] col);
        logic [1:0] hi;
        logic [1:0] lo;
        logic [2:0] idx;
        hi = (row > col) ? row : col;
        lo = (row > col) ? col : row;
        case (hi)
            2'd0:    idx = 3'd0;
            2'd1:    idx = 3'd1 + {1'b0, lo};
            default: idx = 3'd3 + {1'b0, lo};
        endcase
        return idx;
    endfunction

endpackage

FILE: sv/srra_fpu.sv
// ----------------------------------------------------------------------------
// Binary64 arithmetic unit
// Multi-cycle multiply, add and subtract with round to nearest even.
// ----------------------------------------------------------------------------
module srra_fpu
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srra_pkg::fpu_op_t op,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic              done,
    output logic [63:0]       result
);
    import srra_pkg::*;

    localparam int          SW          = 108;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ALIGN,
        F_ADD,
        F_LNORM,
        F_EXPADJ,
        F_RNORM,
        F_ROUND
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [2:0]           stage_reg, stage_next;
    logic [SW-1:0]        sig_reg, sig_next;
    logic signed [13:0]   exp_reg, exp_next;
    logic                 sign_reg, sign_next;
    logic                 sticky_reg, sticky_next;
    logic                 sub_reg, sub_next;
    logic [52:0]          ma_reg, ma_next;
    logic [52:0]          mb_reg, mb_next;
    logic [10:0]          d_reg, d_next;
    logic [SW-1:0]        pp_reg, pp_next;
    logic [56:0]          ys_reg, ys_next;
    logic [6:0]           rsh_reg, rsh_next;
    logic [63:0]          result_reg, result_next;
    logic                 done_reg, done_next;

    logic [10:0]          ea, eb, ea_eff, eb_eff;
    logic [51:0]          fa, fb;
    logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic                 sb_eff, a_ge;
    logic signed [13:0]   eua, eub;
    logic [26:0]          mul_x, mul_y;
    logic [53:0]          mul_p;
    logic [6:0]           amt;
    logic [56:0]          y_full, x_full, y_shift;
    logic [57:0]          sum;
    logic signed [13:0]   be;
    logic signed [13:0]   be_round;
    logic [52:0]          mant;
    logic                 guard, rsticky, inc;
    logic [53:0]          rounded;
    logic [52:0]          mant_final;

    always_comb
    begin
        ea     = a[62:52];
        eb     = b[62:52];
        fa     = a[51:0];
        fb     = b[51:0];
        a_nan  = (&ea) & (|fa);
        b_nan  = (&eb) & (|fb);
        a_inf  = (&ea) & ~(|fa);
        b_inf  = (&eb) & ~(|fb);
        a_zero = ~(|a[62:0]);
        b_zero = ~(|b[62:0]);
        ea_eff = (ea == 11'd0) ? 11'd1 : ea;
        eb_eff = (eb == 11'd0) ? 11'd1 : eb;
        eua    = $signed({3'b000, ea_eff}) - 14'sd1023;
        eub    = $signed({3'b000, eb_eff}) - 14'sd1023;
        sb_eff = b[63] ^ (op == FOP_SUB);
        a_ge   = a[62:0] >= b[62:0];
    end

    always_comb
    begin
        mul_x = stage_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        mul_y = stage_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        mul_p = mul_x * mul_y;
    end

    always_comb
    begin
        amt     = 7'd64 >> stage_reg;
        y_full  = {mb_reg, 4'b0000};
        x_full  = {ma_reg, 4'b0000};
        if (d_reg >= 11'd57)
        begin
            y_shift = {56'd0, |mb_reg};
        end
        else
        begin
            y_shift = (y_full >> d_reg[5:0])
                    | {56'd0, |(y_full & ((57'd1 << d_reg[5:0]) - 57'd1))};
        end
        if (sub_reg)
        begin
            sum = {1'b0, x_full} - {1'b0, ys_reg};
        end
        else
        begin
            sum = {1'b0, x_full} + {1'b0, ys_reg};
        end
        be       = exp_reg + 14'sd1130;
        mant     = sig_reg[107:55];
        guard    = sig_reg[54];
        rsticky  = (|sig_reg[53:0]) | sticky_reg;
        inc      = guard & (rsticky | mant[0]);
        rounded  = {1'b0, mant} + {53'd0, inc};
        if (rounded[53])
        begin
            mant_final = rounded[53:1];
            be_round   = exp_reg + 14'sd1;
        end
        else
        begin
            mant_final = rounded[52:0];
            be_round   = exp_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        stage_next  = stage_reg;
        sig_next    = sig_reg;
        exp_next    = exp_reg;
        sign_next   = sign_reg;
        sticky_next = sticky_reg;
        sub_next    = sub_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        d_next      = d_reg;
        pp_next     = pp_reg;
        ys_next     = ys_reg;
        rsh_next    = rsh_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    stage_next  = 3'd0;
                    sticky_next = 1'b0;
                    sig_next    = '0;
                    if (op == FOP_MUL)
                    begin
                        if (a_nan)
                        begin
                            result_next = a | QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            result_next = b | QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if ((a_inf & b_zero) | (b_inf & a_zero))
                        begin
                            result_next = DEFAULT_NAN;
                            done_next   = 1'b1;
                        end
                        else if (a_inf | b_inf)
                        begin
                            result_next = {a[63] ^ b[63], 11'h7FF, 52'd0};
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            ma_next    = {|ea, fa};
                            mb_next    = {|eb, fb};
                            exp_next   = eua + eub - 14'sd104;
                            sign_next  = a[63] ^ b[63];
                            state_next = F_MUL;
                        end
                    end
                    else
                    begin
                        if (a_nan)
                        begin
                            result_next = a | QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            result_next = b | QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if (a_inf & b_inf & (a[63] != sb_eff))
                        begin
                            result_next = DEFAULT_NAN;
                            done_next   = 1'b1;
                        end
                        else if (a_inf)
                        begin
                            result_next = a;
                            done_next   = 1'b1;
                        end
                        else if (b_inf)
                        begin
                            result_next = {sb_eff, 11'h7FF, 52'd0};
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            sub_next = a[63] != sb_eff;
                            if (a_ge)
                            begin
                                ma_next   = {|ea, fa};
                                mb_next   = {|eb, fb};
                                d_next    = ea_eff - eb_eff;
                                exp_next  = eua - 14'sd56;
                                sign_next = a[63];
                            end
                            else
                            begin
                                ma_next   = {|eb, fb};
                                mb_next   = {|ea, fa};
                                d_next    = eb_eff - ea_eff;
                                exp_next  = eub - 14'sd56;
                                sign_next = sb_eff;
                            end
                            state_next = F_ALIGN;
                        end
                    end
                end
            end
            F_MUL:
            begin
                if (stage_reg != 3'd4)
                begin
                    pp_next = SW'({54'd0, mul_p})
                            << ((stage_reg == 3'd3) ? 7'd54 :
                                (stage_reg == 3'd0) ? 7'd0 : 7'd27);
                end
                if (stage_reg != 3'd0)
                begin
                    sig_next = sig_reg + pp_reg;
                end
                if (stage_reg == 3'd4)
                begin
                    stage_next = 3'd0;
                    state_next = F_LNORM;
                end
                else
                begin
                    stage_next = stage_reg + 3'd1;
                end
            end
            F_ALIGN:
            begin
                ys_next    = y_shift;
                state_next = F_ADD;
            end
            F_ADD:
            begin
                sig_next = SW'(sum);
                if ((sum == 58'd0) && sub_reg)
                begin
                    sign_next = 1'b0;
                end
                stage_next = 3'd0;
                state_next = F_LNORM;
            end
            F_LNORM:
            begin
                if ((stage_reg == 3'd0) && (sig_reg == '0))
                begin
                    result_next = {sign_reg, 63'd0};
                    done_next   = 1'b1;
                    state_next  = F_IDLE;
                end
                else
                begin
                    if ((sig_reg >> (8'd108 - {1'b0, amt})) == '0)
                    begin
                        sig_next = sig_reg << amt;
                        exp_next = exp_reg - $signed({7'd0, amt});
                    end
                    if (stage_reg == 3'd6)
                    begin
                        state_next = F_EXPADJ;
                    end
                    else
                    begin
                        stage_next = stage_reg + 3'd1;
                    end
                end
            end
            F_EXPADJ:
            begin
                if (be <= 14'sd0)
                begin
                    rsh_next = ((14'sd1 - be) > 14'sd127) ? 7'd127 : 7'(14'sd1 - be);
                    exp_next = 14'sd1;
                end
                else
                begin
                    rsh_next = 7'd0;
                    exp_next = be;
                end
                stage_next = 3'd0;
                state_next = F_RNORM;
            end
            F_RNORM:
            begin
                if (rsh_reg[3'd6 - stage_reg])
                begin
                    sticky_next = sticky_reg | (|(sig_reg & ((SW'(1) << amt) - SW'(1))));
                    sig_next    = sig_reg >> amt;
                end
                if (stage_reg == 3'd6)
                begin
                    state_next = F_ROUND;
                end
                else
                begin
                    stage_next = stage_reg + 3'd1;
                end
            end
            F_ROUND:
            begin
                if (be_round >= 14'sd2047)
                begin
                    result_next = {sign_reg, 11'h7FF, 52'd0};
                end
                else
                begin
                    result_next = {sign_reg, mant_final[52] ? be_round[10:0] : 11'd0,
                                   mant_final[51:0]};
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            stage_reg <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg    <= sig_next;
        exp_reg    <= exp_next;
        sign_reg   <= sign_next;
        sticky_reg <= sticky_next;
        sub_reg    <= sub_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        d_reg      <= d_next;
        pp_reg     <= pp_next;
        ys_reg     <= ys_next;
        rsh_reg    <= rsh_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/srra_datapath.sv
// ----------------------------------------------------------------------------
// Accumulator datapath
// Input registers, point product and camera accumulator memories, and the
// shared binary64 unit with its operand selection.
// ----------------------------------------------------------------------------
module srra_datapath
#(
    parameter int CAMERAS = srra_pkg::CAMERAS_DEFAULT,
    parameter int POINTS  = srra_pkg::POINTS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  srra_pkg::ctrl_t   ctrl,
    input  logic [1:0]        cmd,
    input  logic [11:0]       b_address,
    input  logic [11:0]       point_index,
    input  logic [5:0][63:0]  mat,
    input  logic [2:0][63:0]  vec,
    output srra_pkg::stat_t   stat,
    output logic              result_valid,
    output logic [63:0]       result_value
);
    import srra_pkg::*;

    localparam int CA_DEPTH = CAMERAS * ROWS_PER_CAMERA;
    localparam int PP_DEPTH = POINTS * DIM;
    localparam int CAW      = $clog2(CA_DEPTH);
    localparam int PPW      = $clog2(PP_DEPTH);

    logic [1:0]       cmd_reg;
    logic [11:0]      addr_reg;
    logic [11:0]      pt_reg;
    logic [5:0][63:0] mat_reg;
    logic [2:0][63:0] vec_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      tmp_reg;
    logic [63:0]      pp_q_reg;
    logic [63:0]      ca_q_reg;
    logic             result_valid_reg;
    logic [63:0]      result_value_reg;

    logic [63:0]      pp_mem [PP_DEPTH];
    logic [63:0]      ca_mem [CA_DEPTH];

    logic [31:0]      addr_wide;
    logic [31:0]      pp_wide;
    logic [1:0]       pp_sel;
    logic [CAW-1:0]   ca_idx;
    logic [PPW-1:0]   pp_idx;
    logic [63:0]      fpu_a;
    logic [63:0]      fpu_b;
    logic             fpu_done;
    logic [63:0]      fpu_res;

    always_comb
    begin
        addr_wide = {20'd0, addr_reg};
        pp_sel    = ctrl.pp_wr ? ctrl.row : ctrl.col;
        pp_wide   = ({20'd0, pt_reg} << 1) + {20'd0, pt_reg} + {30'd0, pp_sel};
        ca_idx    = addr_wide[CAW-1:0];
        pp_idx    = pp_wide[PPW-1:0];
        if (ctrl.fpu_op == FOP_MUL)
        begin
            if (cmd_reg == CMD_LOAD_POINT)
            begin
                fpu_a = mat_reg[tri_index(ctrl.row, ctrl.col)];
                fpu_b = vec_reg[ctrl.col];
            end
            else
            begin
                fpu_a = vec_reg[ctrl.col];
                fpu_b = pp_q_reg;
            end
        end
        else
        begin
            fpu_a = acc_reg;
            fpu_b = tmp_reg;
        end
    end

    srra_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.fpu_start),
        .op     (ctrl.fpu_op),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg  <= cmd;
            addr_reg <= b_address;
            pt_reg   <= point_index;
            mat_reg  <= mat;
            vec_reg  <= vec;
        end
        if (ctrl.acc_zero)
        begin
            acc_reg <= 64'd0;
        end
        else if (ctrl.acc_from_ca)
        begin
            acc_reg <= ca_q_reg;
        end
        else if (ctrl.acc_from_fpu)
        begin
            acc_reg <= fpu_res;
        end
        if (ctrl.tmp_from_fpu)
        begin
            tmp_reg <= fpu_res;
        end
        if (ctrl.result_strobe)
        begin
            result_value_reg <= stat.addr_ok ? ca_q_reg : 64'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pp_wr)
        begin
            pp_mem[pp_idx] <= fpu_res;
        end
        if (ctrl.pp_rd)
        begin
            pp_q_reg <= pp_mem[pp_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ca_wr_vec)
        begin
            ca_mem[ca_idx] <= vec_reg[0];
        end
        else if (ctrl.ca_wr_acc)
        begin
            ca_mem[ca_idx] <= fpu_res;
        end
        if (ctrl.ca_rd)
        begin
            ca_q_reg <= ca_mem[ca_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctrl.result_strobe;
        end
    end

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.addr_ok  = addr_wide < 32'(CA_DEPTH);
        stat.pt_ok    = {20'd0, pt_reg} < 32'(POINTS);
        stat.fpu_done = fpu_done;
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;

endmodule

FILE: sv/srra_controller.sv
// ----------------------------------------------------------------------------
// Accumulator controller
// Sequences each command through the memories and the shared binary64 unit.
// ----------------------------------------------------------------------------
`include "schur_reduced_rhs_accumulator_core_assert.svh"

module srra_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  srra_pkg::stat_t stat,
    output srra_pkg::ctrl_t ctrl
);
    import srra_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DISPATCH,
        C_LP_ZERO,
        C_LP_MUL,
        C_LP_MWAIT,
        C_LP_ADD,
        C_LP_AWAIT,
        C_OBS_RD,
        C_OBS_MUL,
        C_OBS_MWAIT,
        C_OBS_SUB,
        C_OBS_SWAIT,
        C_RD_ISSUE,
        C_RD_OUT
    } cstate_t;

    cstate_t    state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ctrl       = '0;
        ctrl.fpu_op = FOP_MUL;
        ctrl.row   = row_reg;
        ctrl.col   = col_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch = 1'b1;
                    state_next = C_DISPATCH;
                end
            end
            C_DISPATCH:
            begin
                row_next = 2'd0;
                col_next = 2'd0;
                case (stat.cmd)
                    CMD_LOAD_POINT:
                    begin
                        state_next = stat.pt_ok ? C_LP_ZERO : C_IDLE;
                    end
                    CMD_LOAD_CAMERA:
                    begin
                        ctrl.ca_wr_vec = stat.addr_ok;
                        state_next     = C_IDLE;
                    end
                    CMD_OBSERVE:
                    begin
                        state_next = (stat.addr_ok && stat.pt_ok) ? C_OBS_RD : C_IDLE;
                    end
                    default:
                    begin
                        state_next = C_RD_ISSUE;
                    end
                endcase
            end
            C_LP_ZERO:
            begin
                ctrl.acc_zero = 1'b1;
                state_next    = C_LP_MUL;
            end
            C_LP_MUL:
            begin
                ctrl.fpu_start = 1'b1;
                state_next     = C_LP_MWAIT;
            end
            C_LP_MWAIT:
            begin
                if (stat.fpu_done)
                begin
                    ctrl.tmp_from_fpu = 1'b1;
                    state_next        = C_LP_ADD;
                end
            end
            C_LP_ADD:
            begin
                ctrl.fpu_op    = FOP_ADD;
                ctrl.fpu_start = 1'b1;
                state_next     = C_LP_AWAIT;
            end
            C_LP_AWAIT:
            begin
                ctrl.fpu_op = FOP_ADD;
                if (stat.fpu_done)
                begin
                    ctrl.acc_from_fpu = 1'b1;
                    if (col_reg != 2'd2)
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = C_LP_MUL;
                    end
                    else
                    begin
                        ctrl.pp_wr = 1'b1;
                        col_next   = 2'd0;
                        if (row_reg != 2'd2)
                        begin
                            row_next   = row_reg + 2'd1;
                            state_next = C_LP_ZERO;
                        end
                        else
                        begin
                            state_next = C_IDLE;
                        end
                    end
                end
            end
            C_OBS_RD:
            begin
                ctrl.pp_rd = 1'b1;
                ctrl.ca_rd = (col_reg == 2'd0);
                state_next = C_OBS_MUL;
            end
            C_OBS_MUL:
            begin
                ctrl.acc_from_ca = (col_reg == 2'd0);
                ctrl.fpu_start   = 1'b1;
                state_next       = C_OBS_MWAIT;
            end
            C_OBS_MWAIT:
            begin
                if (stat.fpu_done)
                begin
                    ctrl.tmp_from_fpu = 1'b1;
                    state_next        = C_OBS_SUB;
                end
            end
            C_OBS_SUB:
            begin
                ctrl.fpu_op    = FOP_SUB;
                ctrl.fpu_start = 1'b1;
                state_next     = C_OBS_SWAIT;
            end
            C_OBS_SWAIT:
            begin
                ctrl.fpu_op = FOP_SUB;
                if (stat.fpu_done)
                begin
                    ctrl.acc_from_fpu = 1'b1;
                    if (col_reg != 2'd2)
                    begin
                        col_next   = col_reg + 2'd1;
                        state_next = C_OBS_RD;
                    end
                    else
                    begin
                        ctrl.ca_wr_acc = 1'b1;
                        state_next     = C_IDLE;
                    end
                end
            end
            C_RD_ISSUE:
            begin
                ctrl.ca_rd = stat.addr_ok;
                state_next = C_RD_OUT;
            end
            C_RD_OUT:
            begin
                ctrl.result_strobe = 1'b1;
                state_next         = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
        busy_next = (state_next != C_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    `SRRA_ASSERT_NXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy, "Accepted transfer did not raise busy.")
    `SRRA_ASSERT_IMP(a_result_only_read, clk, rst_n, ctrl.result_strobe, stat.cmd == CMD_READ, "Result produced for a command other than read.")
    `SRRA_ASSERT_NEVER(a_single_write, clk, rst_n, ctrl.pp_wr && (ctrl.ca_wr_acc || ctrl.ca_wr_vec), "Both memories written in one cycle.")

endmodule

FILE: sv/schur_reduced_rhs_accumulator_core.sv
// ----------------------------------------------------------------------------
// Reduced camera right-hand side accumulator
// Computes b = p - E' Ci q for a bundle-adjustment Schur complement in
// binary64, with per-point products and per-camera accumulators held in memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item is finished. A read returns its value on result_value for one
// cycle with result_valid high, after the dispatch, issue and output states,
// and cannot be held off. Every arithmetic step runs in one shared binary64
// unit, one operation at a time. The memories are not cleared by reset;
// entries must be loaded before they are used.
module schur_reduced_rhs_accumulator_core
#(
    parameter int CAMERAS = srra_pkg::CAMERAS_DEFAULT,
    parameter int POINTS  = srra_pkg::POINTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [11:0] b_address,
    input  logic [11:0] point_index,
    input  logic [63:0] mat_0,
    input  logic [63:0] mat_1,
    input  logic [63:0] mat_2,
    input  logic [63:0] mat_3,
    input  logic [63:0] mat_4,
    input  logic [63:0] mat_5,
    input  logic [63:0] vec_0,
    input  logic [63:0] vec_1,
    input  logic [63:0] vec_2,
    output logic        result_valid,
    output logic [63:0] result_value
);
    import srra_pkg::*;

    ctrl_t            ctrl;
    stat_t            stat;
    logic [5:0][63:0] mat;
    logic [2:0][63:0] vec;

    assign mat = {mat_5, mat_4, mat_3, mat_2, mat_1, mat_0};
    assign vec = {vec_2, vec_1, vec_0};

    srra_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    srra_datapath
    #(
        .CAMERAS (CAMERAS),
        .POINTS  (POINTS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .b_address    (b_address),
        .point_index  (point_index),
        .mat          (mat),
        .vec          (vec),
        .stat         (stat),
        .result_valid (result_valid),
        .result_value (result_value)
    );

endmodule
